### design/packet_header_field_extractor_defines.svh
// Assertion helpers for the RTL; only phfe_emit includes them.
`ifndef PACKET_HEADER_FIELD_EXTRACTOR_DEFINES_SVH
`define PACKET_HEADER_FIELD_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PHFE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define PHFE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/phfe_pkg.sv
package phfe_pkg;

   localparam int MAX_VLANS  = 3;
   localparam int NUM_FIELDS = 17;
   localparam logic [4:0] LAST_CODE = 5'(NUM_FIELDS - 1);
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // csr indexes
   localparam logic CSR_GRE_UNPACK  = 1'b0;
   localparam logic CSR_LEN_FROM_IP = 1'b1;

   // parse status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNC     = 3'd1;
   localparam logic [2:0] ST_VLANS     = 3'd2;
   localparam logic [2:0] ST_IP6_EXT   = 3'd3;
   localparam logic [2:0] ST_ARP       = 3'd4;
   localparam logic [2:0] ST_UNK_ETYPE = 3'd5;
   localparam logic [2:0] ST_BAD_GRE   = 3'd6;

   // ethertypes
   localparam logic [15:0] ET_VLAN   = 16'h8100;
   localparam logic [15:0] ET_IPV4   = 16'h0800;
   localparam logic [15:0] ET_IPV6   = 16'h86DD;
   localparam logic [15:0] ET_ARP    = 16'h0806;
   localparam logic [15:0] ET_ERSPAN = 16'h88BE;

   // ip protocol numbers
   localparam logic [7:0] PR_HOPOPT = 8'd0;
   localparam logic [7:0] PR_TCP    = 8'd6;
   localparam logic [7:0] PR_UDP    = 8'd17;
   localparam logic [7:0] PR_ROUTE  = 8'd43;
   localparam logic [7:0] PR_FRAG   = 8'd44;
   localparam logic [7:0] PR_GRE    = 8'd47;
   localparam logic [7:0] PR_ESP    = 8'd50;
   localparam logic [7:0] PR_AH     = 8'd51;
   localparam logic [7:0] PR_DSTOPT = 8'd60;

   typedef enum logic [3:0] {
      LAYER_ETH, LAYER_VLAN, LAYER_IP4, LAYER_OPT, LAYER_IP6,
      LAYER_FRAG6, LAYER_TCP, LAYER_UDP, LAYER_GRE, LAYER_DONE
   } phfe_layer_type;

   typedef enum logic [1:0] {
      CTX_OUTER, CTX_GRE_IP4, CTX_ERSPAN
   } phfe_ctx_type;

   typedef struct packed {
      logic [NUM_FIELDS-1:0][63:0] rec;
      logic [2:0]                  status;
   } phfe_frame_type;

endpackage

### design/phfe_front.sv
module phfe_front
   import phfe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  logic           csr_index,
   input  logic           csr_write_data,
   input  logic           push,
   input  logic           full,
   input  logic [7:0]     frame_byte,
   input  logic           frame_end,
   input  logic [15:0]    sampled_length,
   output logic           frame_push,
   output phfe_frame_type frame_data
);

   logic gre_en_ff, len_ip_ff;
   logic [15:0] off_ff, off_in, start_ff, start_in;
   logic [5:0]  need_ff, need_in;
   phfe_layer_type layer_ff, layer_in;
   phfe_ctx_type   ctx_ff, ctx_in;
   logic [2:0]  tags_ff, tags_in, status_ff, status_in;
   logic [7:0]  pend_ff, pend_in;
   logic        lens_ff, lens_in;
   logic [NUM_FIELDS-1:0][63:0] rec_ff, rec_in;
   logic [7:0]  hbuf_ff [40];
   logic [7:0]  hb [40];

   logic        accept, parse, complete, do_l4, do_disp, unpack, df, mf, frag;
   logic [15:0] pos, disp_type, total, fo, t16;
   logic [7:0]  l4_proto, proto;
   logic [5:0]  optlen;
   logic [2:0]  fin_status;

   assign accept = push && !full;

   always_comb begin
      off_in = off_ff; start_in = start_ff; need_in = need_ff; layer_in = layer_ff;
      ctx_in = ctx_ff; tags_in = tags_ff; status_in = status_ff; pend_in = pend_ff;
      lens_in = lens_ff; rec_in = rec_ff; hb = hbuf_ff;
      do_l4 = 1'b0; l4_proto = '0; do_disp = 1'b0; disp_type = '0;
      unpack = 1'b0; fin_status = ST_OK; frame_push = 1'b0; frame_data = '0;
      parse = accept && (layer_ff != LAYER_DONE) && (off_ff != 16'hFFFF) &&
              (off_ff >= start_ff);
      pos = off_ff - start_ff;
      if (parse && pos < 16'd40) begin
         hb[pos[5:0]] = frame_byte;
      end
      complete = parse && ((17'(pos) + 17'd1) >= 17'(need_ff));
      df    = hb[6][6];
      mf    = hb[6][5];
      fo    = {hb[6][4:0], hb[7], 3'b000};
      frag  = mf || (fo != 16'd0);
      total = {hb[2], hb[3]};
      proto = hb[9];
      t16   = {hb[2], hb[3]};
      optlen = (hb[0][3:0] > 4'd5) ? {4'(hb[0][3:0] - 4'd5), 2'b00} : 6'd0;

      // ports of an outer or ERSPAN-inner TCP header count as soon as they arrive
      if (parse && layer_ff == LAYER_TCP && pos == 16'd3 && ctx_ff != CTX_GRE_IP4) begin
         rec_in[14] = {48'd0, hb[0], hb[1]};
         rec_in[15] = {48'd0, hb[2], hb[3]};
      end

      if (complete) begin
         case (layer_ff)
            LAYER_ETH: begin
               rec_in[0] = {16'd0, hb[0], hb[1], hb[2], hb[3], hb[4], hb[5]};
               rec_in[1] = {16'd0, hb[6], hb[7], hb[8], hb[9], hb[10], hb[11]};
               tags_in   = 3'd0;
               do_disp   = 1'b1;
               disp_type = {hb[12], hb[13]};
            end
            LAYER_VLAN: begin
               if (tags_ff == 3'd0) begin
                  rec_in[2] = {52'd0, hb[0][3:0], hb[1]};
               end
               if (tags_ff >= 3'(MAX_VLANS)) begin
                  layer_in = LAYER_DONE; status_in = ST_VLANS;
               end else begin
                  tags_in   = tags_ff + 3'd1;
                  do_disp   = 1'b1;
                  disp_type = {hb[2], hb[3]};
               end
            end
            LAYER_IP4: begin
               rec_in[3]  = 64'd4;
               rec_in[4]  = 64'd0;
               rec_in[5]  = {32'd0, hb[12], hb[13], hb[14], hb[15]};
               rec_in[6]  = 64'd0;
               rec_in[7]  = {32'd0, hb[16], hb[17], hb[18], hb[19]};
               rec_in[8]  = {56'd0, hb[8]};
               rec_in[9]  = {48'd0, total};
               rec_in[12] = {56'd0, proto};
               if (ctx_ff == CTX_GRE_IP4) begin
                  rec_in[10] = {61'd0, frag, rec_ff[10][1], df};
               end else begin
                  rec_in[10] = {61'd0, frag, mf, df};
                  rec_in[11] = {48'd0, fo};
               end
               if (ctx_ff == CTX_OUTER && !len_ip_ff) begin
                  lens_in = 1'b1;
               end else begin
                  lens_in = 1'b0; rec_in[13] = {48'd0, total};
               end
               if (ctx_ff != CTX_GRE_IP4 && fo != 16'd0) begin
                  layer_in = LAYER_DONE; status_in = ST_OK;
               end else if (proto == PR_TCP || proto == PR_UDP ||
                            (proto == PR_GRE && ctx_ff == CTX_OUTER && gre_en_ff)) begin
                  if (optlen != 6'd0) begin
                     pend_in  = proto;
                     layer_in = LAYER_OPT; need_in = optlen; start_in = off_ff + 16'd1;
                  end else begin
                     do_l4 = 1'b1; l4_proto = proto;
                  end
               end else begin
                  layer_in = LAYER_DONE; status_in = ST_OK;
               end
            end
            LAYER_OPT: begin
               do_l4 = 1'b1; l4_proto = pend_ff;
            end
            LAYER_IP6: begin
               rec_in[3]  = 64'd6;
               rec_in[4]  = {hb[8], hb[9], hb[10], hb[11], hb[12], hb[13], hb[14], hb[15]};
               rec_in[5]  = {hb[16], hb[17], hb[18], hb[19], hb[20], hb[21], hb[22], hb[23]};
               rec_in[6]  = {hb[24], hb[25], hb[26], hb[27], hb[28], hb[29], hb[30], hb[31]};
               rec_in[7]  = {hb[32], hb[33], hb[34], hb[35], hb[36], hb[37], hb[38], hb[39]};
               rec_in[8]  = {56'd0, hb[7]};
               rec_in[9]  = {48'd0, hb[4], hb[5]};
               rec_in[12] = {56'd0, hb[6]};
               if (ctx_ff == CTX_OUTER && !len_ip_ff) begin
                  lens_in = 1'b1;
               end else begin
                  lens_in = 1'b0; rec_in[13] = {48'd0, hb[4], hb[5]};
               end
               if (hb[6] == PR_FRAG) begin
                  layer_in = LAYER_FRAG6; need_in = 6'd8; start_in = off_ff + 16'd1;
               end else if (hb[6] == PR_HOPOPT || hb[6] == PR_ROUTE || hb[6] == PR_ESP ||
                            hb[6] == PR_AH || hb[6] == PR_DSTOPT) begin
                  layer_in = LAYER_DONE; status_in = ST_IP6_EXT;
               end else begin
                  do_l4 = 1'b1; l4_proto = hb[6];
               end
            end
            LAYER_FRAG6: begin
               rec_in[10] = {61'd0, 1'b1, t16[0], rec_ff[10][0]};
               rec_in[11] = {48'd0, t16[15:3], 3'b000};
               layer_in = LAYER_DONE; status_in = ST_OK;
            end
            LAYER_TCP: begin
               rec_in[14] = {48'd0, hb[0], hb[1]};
               rec_in[15] = {48'd0, hb[2], hb[3]};
               rec_in[16] = {58'd0, hb[13][5:0]};
               layer_in = LAYER_DONE; status_in = ST_OK;
            end
            LAYER_UDP: begin
               rec_in[14] = {48'd0, hb[0], hb[1]};
               rec_in[15] = {48'd0, hb[2], hb[3]};
               layer_in = LAYER_DONE; status_in = ST_OK;
            end
            LAYER_GRE: begin
               if (hb[0] != 8'd0 || hb[1] != 8'd0) begin
                  layer_in = LAYER_DONE; status_in = ST_BAD_GRE;
               end else if (t16 == ET_IPV4) begin
                  ctx_in = CTX_GRE_IP4;
                  layer_in = LAYER_IP4; need_in = 6'd20; start_in = off_ff + 16'd1;
               end else if (t16 == ET_ERSPAN) begin
                  ctx_in = CTX_ERSPAN;
                  layer_in = LAYER_ETH; need_in = 6'd14; start_in = off_ff + 16'd1;
               end else begin
                  layer_in = LAYER_DONE; status_in = ST_BAD_GRE;
               end
            end
            default: begin
               layer_in = LAYER_DONE; status_in = ST_OK;
            end
         endcase
      end

      if (do_l4) begin
         unpack = (ctx_ff == CTX_OUTER) && gre_en_ff;
         start_in = off_ff + 16'd1;
         if (l4_proto == PR_TCP) begin
            layer_in = LAYER_TCP; need_in = 6'd20;
         end else if (l4_proto == PR_UDP) begin
            layer_in = LAYER_UDP; need_in = 6'd8;
         end else if (l4_proto == PR_GRE && unpack) begin
            layer_in = LAYER_GRE; need_in = 6'd4;
         end else begin
            layer_in = LAYER_DONE; status_in = ST_OK;
         end
      end

      if (do_disp) begin
         start_in = off_ff + 16'd1;
         if (disp_type == ET_VLAN) begin
            layer_in = LAYER_VLAN; need_in = 6'd4;
         end else if (disp_type == ET_IPV4) begin
            layer_in = LAYER_IP4; need_in = 6'd20;
         end else if (disp_type == ET_IPV6) begin
            layer_in = LAYER_IP6; need_in = 6'd40;
         end else if (disp_type == ET_ARP) begin
            layer_in = LAYER_DONE; status_in = ST_ARP;
         end else begin
            layer_in = LAYER_DONE; status_in = ST_UNK_ETYPE;
         end
      end

      if (accept && off_ff != 16'hFFFF) begin
         off_in = off_ff + 16'd1;
      end

      if (accept && frame_end) begin
         if (layer_in == LAYER_DONE) begin
            fin_status = status_in;
         end else if (layer_in == LAYER_TCP && ctx_in != CTX_GRE_IP4 &&
                      off_in >= start_in && (off_in - start_in) >= 16'd4) begin
            fin_status = ST_OK;
         end else begin
            fin_status = ST_TRUNC;
         end
         frame_push        = 1'b1;
         frame_data.rec    = rec_in;
         frame_data.status = fin_status;
         if (lens_in) begin
            frame_data.rec[13] = {48'd0, sampled_length};
         end
         // new frame
         off_in = '0; start_in = '0; need_in = 6'd14; layer_in = LAYER_ETH;
         ctx_in = CTX_OUTER; tags_in = '0; status_in = ST_OK; pend_in = '0;
         lens_in = 1'b0; rec_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gre_en_ff <= 1'b0; len_ip_ff <= 1'b0;
         off_ff <= '0; start_ff <= '0; need_ff <= 6'd14; layer_ff <= LAYER_ETH;
         ctx_ff <= CTX_OUTER; tags_ff <= '0; status_ff <= ST_OK; pend_ff <= '0;
         lens_ff <= 1'b0; rec_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GRE_UNPACK:  gre_en_ff <= csr_write_data;
               CSR_LEN_FROM_IP: len_ip_ff <= csr_write_data;
               default: ;
            endcase
         end
         off_ff <= off_in; start_ff <= start_in; need_ff <= need_in; layer_ff <= layer_in;
         ctx_ff <= ctx_in; tags_ff <= tags_in; status_ff <= status_in; pend_ff <= pend_in;
         lens_ff <= lens_in; rec_ff <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      hbuf_ff <= hb;
   end

endmodule

### design/phfe_fifo.sv
module phfe_fifo
   import phfe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  phfe_frame_type wr_data,
   output logic           full,
   input  logic           rd_en,
   output phfe_frame_type rd_data,
   output logic           empty
);

   phfe_frame_type mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   assign full    = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0; rd_ptr_ff <= '0; count_ff <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
      end
   end

endmodule

### design/phfe_emit.sv
`include "packet_header_field_extractor_defines.svh"
module phfe_emit
   import phfe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fifo_empty,
   input  phfe_frame_type fifo_data,
   output logic           fifo_pop,
   input  logic           rsp_pop,
   output logic           rsp_empty,
   output logic [4:0]     rsp_field_code,
   output logic [63:0]    rsp_field_value,
   output logic [2:0]     rsp_parse_status,
   output logic           rsp_last_field
);

   phfe_frame_type cur_ff;
   logic           valid_ff;
   logic [4:0]     idx_ff;
   logic           take, last;

   assign last     = (idx_ff == LAST_CODE);
   assign take     = rsp_pop && valid_ff;
   assign fifo_pop = !fifo_empty && (!valid_ff || (take && last));

   assign rsp_empty        = !valid_ff;
   assign rsp_field_code   = idx_ff;
   assign rsp_field_value  = cur_ff.rec[idx_ff];
   assign rsp_parse_status = cur_ff.status;
   assign rsp_last_field   = last;

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         cur_ff <= fifo_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; idx_ff <= '0;
      end else if (fifo_pop) begin
         valid_ff <= 1'b1; idx_ff <= '0;
      end else if (take) begin
         if (last) begin
            valid_ff <= 1'b0; idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + 5'd1;
         end
      end
   end

   `PHFE_ASSERT_NOW(a_idx_range, valid_ff, idx_ff <= LAST_CODE)
   `PHFE_ASSERT_NEXT(a_idx_step, take && !last, idx_ff == $past(idx_ff) + 5'd1)
   `PHFE_ASSERT_NEXT(a_drain, take && last && fifo_empty, rsp_empty)
   `PHFE_ASSERT_NEXT(a_reload, fifo_pop, valid_ff && idx_ff == 5'd0)

endmodule

### design/packet_header_field_extractor.sv
// Frame header field extractor.
// Input queue port: one frame byte per word (req_frame_byte, req_frame_end,
// req_sampled_length); a word is taken when req_push is high and req_full low.
// The front parser handles one byte per cycle while req_full is low: Ethernet,
// VLAN tags, IPv4/IPv6, TCP/UDP/GRE, with optional GRE unpacking (csr index 0)
// and IP-header length reporting (csr index 1); the user must make csr writes
// go in while the block is idle, which the block itself does not enforce.
// On the frame_end byte the seventeen field records plus status move into a
// two-entry frame queue; the emitter then presents them in field-code order.
// Result queue port: rsp_empty low means a word is on rsp_*; rsp_pop takes it.
// A frame's first record is shown once the frame has passed the frame queue
// and been loaded into the emitter. Throughput: 1 byte per cycle while req_full
// is low; each frame yields seventeen records at the emitter, so frames shorter
// than 17 bytes back the frame queue up, and req_full rises while both queue
// entries hold frames. A stalled receiver only stops the emitter; the parser
// keeps taking bytes until the frame queue fills. Reset (synchronous, active
// high) clears both csr bits, the parse state and both queues.
module packet_header_field_extractor
   import phfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   input  logic [15:0] req_sampled_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [4:0]  rsp_field_code,
   output logic [63:0] rsp_field_value,
   output logic [2:0]  rsp_parse_status,
   output logic        rsp_last_field
);

   logic           frame_push, fifo_empty, fifo_pop;
   phfe_frame_type frame_data, fifo_data;

   // parser: one word per cycle while the frame queue is not full
   phfe_front u_front (
      .clock, .reset,
      .csr_write_enable, .csr_index, .csr_write_data,
      .push(req_push), .full(req_full),
      .frame_byte(req_frame_byte), .frame_end(req_frame_end),
      .sampled_length(req_sampled_length),
      .frame_push, .frame_data
   );

   // finished frames wait here
   phfe_fifo u_fifo (
      .clock, .reset,
      .wr_en(frame_push), .wr_data(frame_data), .full(req_full),
      .rd_en(fifo_pop), .rd_data(fifo_data), .empty(fifo_empty)
   );

   // record emitter
   phfe_emit u_emit (
      .clock, .reset,
      .fifo_empty, .fifo_data, .fifo_pop,
      .rsp_pop, .rsp_empty, .rsp_field_code, .rsp_field_value,
      .rsp_parse_status, .rsp_last_field
   );

endmodule

### verif/packet_header_field_extractor_test.sv
`timescale 1ns / 1ps

// Frame header extractor testbench.
// Frames are built from Ethernet, VLAN, IPv4/IPv6, TCP/UDP/GRE pieces (some
// truncated or malformed) and pushed one byte per word. A scoreboard replays
// every accepted byte through its own parser and queues the seventeen field
// records each frame end should produce; every popped record is compared
// field by field against the oldest queued one.
module packet_header_field_extractor_test;
   import phfe_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct {
      logic [4:0]  code;
      logic [63:0] value;
      logic [2:0]  status;
      logic        last;
   } field_rec_type;

   // Scoreboard: shadow parser plus queue of expected field records.
   class parse_scoreboard;
      bit gre_en, len_ip;
      int unsigned offs, lstart, need, tags, optlen;
      logic [7:0] pend;
      phfe_layer_type layer;
      phfe_ctx_type ctx;
      bit lsamp;
      logic [2:0] est;
      logic [63:0] rec[NUM_FIELDS];
      logic [7:0] hb[40];
      field_rec_type expected_records[$];
      int errors, frames, records;

      function void clear_frame();
         offs = 0; lstart = 0; need = 14; layer = LAYER_ETH;
         tags = 0; optlen = 0; pend = 0; est = ST_OK;
         ctx = CTX_OUTER; lsamp = 0;
         foreach (rec[i]) rec[i] = '0;
         foreach (hb[i]) hb[i] = '0;
      endfunction

      function logic [63:0] be(int first, int count);
         logic [63:0] v;
         v = '0;
         for (int i = 0; i < count; i++) v = {v[55:0], hb[(first + i) % 40]};
         return v;
      endfunction

      function void go(phfe_layer_type l, int n);
         layer = l; need = n; lstart = offs + 1;
      endfunction

      function void stop_parse(logic [2:0] s);
         layer = LAYER_DONE; est = s;
      endfunction

      function void enter_l4(logic [7:0] p);
         bit unp;
         unp = (ctx == CTX_OUTER) ? gre_en : 1'b0;
         if (p == PR_TCP) go(LAYER_TCP, 20);
         else if (p == PR_UDP) go(LAYER_UDP, 8);
         else if (p == PR_GRE && unp) go(LAYER_GRE, 4);
         else stop_parse(ST_OK);
      endfunction

      function void dispatch(logic [15:0] t);
         if (t == ET_VLAN) go(LAYER_VLAN, 4);
         else if (t == ET_IPV4) go(LAYER_IP4, 20);
         else if (t == ET_IPV6) go(LAYER_IP6, 40);
         else if (t == ET_ARP) stop_parse(ST_ARP);
         else stop_parse(ST_UNK_ETYPE);
      endfunction

      function void set_len(logic [63:0] v);
         if (ctx == CTX_OUTER && !len_ip) lsamp = 1;
         else begin
            lsamp = 0;
            rec[13] = v;
         end
      endfunction

      function void header_done();
         logic [3:0] ihl;
         logic [7:0] proto;
         logic [63:0] total, off;
         logic df, mf, frag;
         logic [15:0] t;
         case (layer)
            LAYER_ETH: begin
               rec[0] = be(0, 6);
               rec[1] = be(6, 6);
               tags = 0;
               dispatch(16'(be(12, 2)));
            end
            LAYER_VLAN: begin
               if (tags == 0) rec[2] = be(0, 2) & 64'hFFF;
               if (tags >= MAX_VLANS) stop_parse(ST_VLANS);
               else begin
                  tags++;
                  dispatch(16'(be(2, 2)));
               end
            end
            LAYER_IP4: begin
               ihl = hb[0][3:0];
               total = be(2, 2);
               proto = hb[9];
               df = hb[6][6];
               mf = hb[6][5];
               off = (be(6, 2) & 64'h1FFF) * 64'd8;
               frag = mf || off != 0;
               rec[3] = 64'd4; rec[4] = 64'd0; rec[5] = be(12, 4);
               rec[6] = 64'd0; rec[7] = be(16, 4);
               rec[8] = 64'(hb[8]); rec[9] = total; rec[12] = 64'(proto);
               if (ctx == CTX_GRE_IP4)
                  rec[10] = (rec[10] & 64'h2) | 64'(df) | (64'(frag) << 2);
               else begin
                  rec[10] = 64'(df) | (64'(mf) << 1) | (64'(frag) << 2);
                  rec[11] = off;
               end
               set_len(total);
               if (ctx != CTX_GRE_IP4 && off != 0) stop_parse(ST_OK);
               else begin
                  optlen = (ihl > 5) ? (ihl - 5) * 4 : 0;
                  if (proto == PR_TCP || proto == PR_UDP ||
                      (proto == PR_GRE && ctx == CTX_OUTER && gre_en)) begin
                     if (optlen > 0) begin
                        pend = proto;
                        go(LAYER_OPT, optlen);
                     end else enter_l4(proto);
                  end else stop_parse(ST_OK);
               end
            end
            LAYER_OPT: enter_l4(pend);
            LAYER_IP6: begin
               proto = hb[6];
               total = be(4, 2);
               rec[3] = 64'd6; rec[4] = be(8, 8); rec[5] = be(16, 8);
               rec[6] = be(24, 8); rec[7] = be(32, 8);
               rec[8] = 64'(hb[7]); rec[9] = total; rec[12] = 64'(proto);
               set_len(total);
               if (proto == PR_FRAG) go(LAYER_FRAG6, 8);
               else if (proto == PR_HOPOPT || proto == PR_ROUTE || proto == PR_ESP ||
                        proto == PR_AH || proto == PR_DSTOPT) stop_parse(ST_IP6_EXT);
               else enter_l4(proto);
            end
            LAYER_FRAG6: begin
               t = 16'(be(2, 2));
               rec[10] = (rec[10] & 64'h1) | (64'(t[0]) << 1) | 64'h4;
               rec[11] = 64'(t & 16'hFFF8);
               stop_parse(ST_OK);
            end
            LAYER_TCP: begin
               rec[14] = be(0, 2); rec[15] = be(2, 2);
               rec[16] = 64'(hb[13] & 8'h3F);
               stop_parse(ST_OK);
            end
            LAYER_UDP: begin
               rec[14] = be(0, 2); rec[15] = be(2, 2);
               stop_parse(ST_OK);
            end
            LAYER_GRE: begin
               t = 16'(be(2, 2));
               if (hb[0] != 0 || hb[1] != 0) stop_parse(ST_BAD_GRE);
               else if (t == ET_IPV4) begin
                  ctx = CTX_GRE_IP4;
                  go(LAYER_IP4, 20);
               end else if (t == ET_ERSPAN) begin
                  ctx = CTX_ERSPAN;
                  go(LAYER_ETH, 14);
               end else stop_parse(ST_BAD_GRE);
            end
            default: stop_parse(ST_OK);
         endcase
      endfunction

      // Called for each accepted word.
      function void take_byte(logic [7:0] b, logic e, logic [15:0] slen);
         int unsigned pos;
         logic [2:0] st;
         field_rec_type r;
         if (layer != LAYER_DONE && offs < 16'hFFFF && offs >= lstart) begin
            pos = offs - lstart;
            if (pos < 40) hb[pos] = b;
            if (layer == LAYER_TCP && pos == 3 && ctx != CTX_GRE_IP4) begin
               rec[14] = be(0, 2);
               rec[15] = be(2, 2);
            end
            if (pos + 1 >= need) header_done();
         end
         if (offs < 16'hFFFF) offs++;
         if (!e) return;
         if (layer == LAYER_DONE) st = est;
         else if (layer == LAYER_TCP && ctx != CTX_GRE_IP4 && offs >= lstart &&
                  offs - lstart >= 4) st = ST_OK;
         else st = ST_TRUNC;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            r.code = 5'(k);
            r.value = (k == 13 && lsamp) ? 64'(slen) : rec[k];
            r.status = st;
            r.last = (k == NUM_FIELDS - 1);
            expected_records.push_back(r);
         end
         frames++;
         clear_frame();
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_record(field_rec_type got);
         field_rec_type w;
         if (expected_records.size() == 0) begin
            report_mismatch($sformatf("unexpected record code %0d", got.code));
            return;
         end
         w = expected_records.pop_front();
         records++;
         if (got.code !== w.code || got.value !== w.value || got.status !== w.status ||
             got.last !== w.last)
            report_mismatch($sformatf("code %0d/%0d value %h/%h status %0d/%0d last %0b/%0b",
               got.code, w.code, got.value, w.value, got.status, w.status,
               got.last, w.last));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic        csr_index = 0;
   logic        csr_write_data = 0;
   logic        req_push = 0;
   logic        req_full;
   logic [7:0]  req_frame_byte = 0;
   logic        req_frame_end = 0;
   logic [15:0] req_sampled_length = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [4:0]  rsp_field_code;
   logic [63:0] rsp_field_value;
   logic [2:0]  rsp_parse_status;
   logic        rsp_last_field;

   packet_header_field_extractor DUT (.*);

   parse_scoreboard sb = new();
   logic [7:0] frame_q[$];
   int idle_pct = 0, stall_pct = 0, hold_cycles = 0;
   int unsigned cycles = 0;
   int unsigned words_sent = 0;
   bit sender_paused = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("packet_header_field_extractor test failed");
         $finish;
      end
   end

   // Receiver: long hold-off when requested, else random stalls.
   always @(negedge clock) begin
      if (reset) rsp_pop <= 0;
      else if (hold_cycles > 0) begin
         rsp_pop <= 0;
         hold_cycles--;
      end else rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      field_rec_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.code = rsp_field_code;
         got.value = rsp_field_value;
         got.status = rsp_parse_status;
         got.last = rsp_last_field;
         sb.check_record(got);
      end
   end

   task automatic write_csr(logic idx, logic val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 0;
      if (idx == CSR_GRE_UNPACK) sb.gre_en = val;
      else sb.len_ip = val;
   endtask

   // Block drained: no record outstanding, plus emitter latency.
   task automatic wait_drained();
      while (sb.expected_records.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // One word; called at a falling edge, returns at a falling edge.
   task automatic send_word(logic [7:0] b, logic e, logic [15:0] slen);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_frame_byte <= b;
      req_frame_end <= e;
      req_sampled_length <= slen;
      do @(posedge clock); while (req_full);
      sb.take_byte(b, e, slen);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      logic [15:0] slen;
      case ($urandom_range(3))
         0: slen = 16'h0000;
         1: slen = 16'hFFFF;
         default: slen = 16'($urandom);
      endcase
      foreach (frame_q[i])
         send_word(frame_q[i], i == frame_q.size() - 1, (i == frame_q.size() - 1) ? slen :
                   16'($urandom));
      frame_q.delete();
   endtask

   task automatic add_rand(int n);
      repeat (n) frame_q.push_back(8'($urandom));
   endtask

   task automatic add16(logic [15:0] v);
      frame_q.push_back(v[15:8]);
      frame_q.push_back(v[7:0]);
   endtask

   function automatic logic [7:0] pick_proto(bit v6);
      int r;
      r = $urandom_range(99);
      if (r < 30) return PR_TCP;
      if (r < 50) return PR_UDP;
      if (r < 72) return PR_GRE;
      if (v6 && r < 84) return PR_FRAG;
      if (v6 && r < 94) begin
         case ($urandom_range(4))
            0: return PR_HOPOPT;
            1: return PR_ROUTE;
            2: return PR_ESP;
            3: return PR_AH;
            default: return PR_DSTOPT;
         endcase
      end
      return 8'($urandom);
   endfunction

   task automatic add_l4(logic [7:0] p, bit nest);
      if (p == PR_TCP) add_rand(20);
      else if (p == PR_UDP) add_rand(8);
      else if (p == PR_GRE && nest) begin
         if ($urandom_range(7) == 0) add16(16'($urandom));
         else add16(16'h0000);
         case ($urandom_range(4))
            0, 1: begin
               add16(ET_IPV4);
               add_ip4(0);
            end
            2, 3: begin
               add16(ET_ERSPAN);
               add_eth(0);
            end
            default: add16(16'($urandom));
         endcase
      end else add_rand(4);
      add_rand($urandom_range(4));
   endtask

   task automatic add_ip4(bit nest);
      logic [3:0] ihl;
      logic [7:0] p;
      logic [15:0] fo;
      ihl = ($urandom_range(4) != 0) ? 4'd5 : 4'($urandom);
      p = pick_proto(0);
      fo = {1'b0, 2'($urandom), 13'd0};
      if ($urandom_range(5) == 0) fo[12:0] = 13'($urandom);
      frame_q.push_back({4'h4, ihl});
      add_rand(3);
      add_rand(2);
      add16(fo);
      add_rand(1);
      frame_q.push_back(p);
      add_rand(10);
      add_rand(ihl > 5 ? (ihl - 5) * 4 : 0);
      add_l4(p, nest);
   endtask

   task automatic add_ip6(bit nest);
      logic [7:0] p;
      p = pick_proto(1);
      add_rand(6);
      frame_q.push_back(p);
      add_rand(33);
      if (p == PR_FRAG) add_rand(8 + $urandom_range(3));
      else add_l4(p, nest);
   endtask

   // nest: GRE payloads may be built (outer frame only).
   task automatic add_eth(bit nest);
      int r;
      add_rand(12);
      r = $urandom_range(9);
      repeat (r < 6 ? 0 : r - 5) begin
         add16(ET_VLAN);
         add_rand(2);
      end
      r = $urandom_range(99);
      if (r < 50) begin
         add16(ET_IPV4);
         add_ip4(nest);
      end else if (r < 82) begin
         add16(ET_IPV6);
         add_ip6(nest);
      end else if (r < 90) begin
         add16(ET_ARP);
         add_rand(28);
      end else begin
         add16(16'($urandom));
         add_rand(20);
      end
   endtask

   task automatic random_frame();
      int n;
      add_eth(1);
      if ($urandom_range(4) == 0) begin
         n = $urandom_range(1, frame_q.size());
         while (frame_q.size() > n) void'(frame_q.pop_back());
      end
      send_frame();
   endtask

   initial begin
      sb.clear_frame();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // receiver holds off long enough for the frame queue to fill and the input to stall
      hold_cycles = 400;
      write_csr(CSR_GRE_UNPACK, 0);
      write_csr(CSR_LEN_FROM_IP, 0);

      // Directed: two one-byte frames, ARP, then TCP cut right after the ports.
      frame_q.push_back(8'hFF);
      send_frame();
      frame_q.push_back(8'h00);
      send_frame();
      add_rand(12); add16(ET_ARP); add_rand(2);
      send_frame();
      add_rand(12); add16(ET_IPV4);
      frame_q.push_back(8'h45); add_rand(5); add16(16'h0000); add_rand(1);
      frame_q.push_back(PR_TCP); add_rand(10); add_rand(4);
      send_frame();
      req_push <= 0;
      wait_drained();

      // Random phases, each with its own register setting and idle mix.
      for (int ph = 0; ph < 4; ph++) begin
         int start;
         write_csr(CSR_GRE_UNPACK, ph == 1 || ph == 2);
         write_csr(CSR_LEN_FROM_IP, ph >= 2);
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         start = words_sent;
         while (words_sent - start < 24) begin
            random_frame();
            // sender pauses once until everything has come out
            if (ph == 3 && !sender_paused) begin
               req_push <= 0;
               @(negedge clock);
               while (sb.expected_records.size() != 0) @(negedge clock);
               sender_paused = 1;
            end
         end
         req_push <= 0;
         wait_drained();
      end

      $display("covered %0d words in %0d frames, %0d field records checked",
               words_sent, sb.frames, sb.records);
      $display("all register combinations, long receiver hold-off, idle mixes");
      if (sb.errors == 0 && sb.expected_records.size() == 0)
         $display("packet_header_field_extractor test passed");
      else
         $display("packet_header_field_extractor test failed");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/phfe_pkg.sv
design/phfe_front.sv
design/phfe_fifo.sv
design/phfe_emit.sv
design/packet_header_field_extractor.sv
verif/packet_header_field_extractor_test.sv
